### rtl/iwo_pkg.sv
package iwo_pkg;

  // Table geometry and sample format
  localparam int TABLE_SEGMENTS = 36;
  localparam int TABLE_DEPTH    = TABLE_SEGMENTS + 1;
  localparam int SAMPLE_BITS    = 14;

  // Phase format: integer table position over an 8-bit fraction
  localparam int FRAC_BITS   = 8;
  localparam int FRAC_ONE    = 1 << FRAC_BITS;
  localparam int PHASE_LIMIT = TABLE_SEGMENTS * FRAC_ONE;
  localparam int PHASE_W     = $clog2(PHASE_LIMIT);
  localparam int PINT_W      = PHASE_W - FRAC_BITS;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Fixed field widths of the transaction ports
  localparam int OP_W          = 1;
  localparam int ENTRY_IDX_W   = 6;
  localparam int ENTRY_VAL_W   = 14;
  localparam int INC_W         = 8;
  localparam int DAC_W         = 16;
  localparam logic [DAC_W-1:0] DAC_MASK = 16'hFFC0;

  // Interpolation datapath widths
  localparam int WGT_W = FRAC_BITS + 1;
  localparam int SUM_W = SAMPLE_BITS + WGT_W;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_INC = 2'd0;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

endpackage

### rtl/interpolating_wavetable_oscillator.sv
// Registered path from input transaction to result: input register, table read
//   register, output register. Throughput: one transaction per cycle while out_stall is low.
// The phase add and the dual-port table read share one stage; the two-tap
//   interpolation sits in the next one. Load transactions give no result.
// Reset (rst_n, synchronous, active low) clears the valid flags, the phase and the
//   increment; table contents are undefined until loaded.
module interpolating_wavetable_oscillator
  import iwo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        in_operation,
  input  logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [ENTRY_VAL_W-1:0] in_entry_value,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DAC_W-1:0]       out_dac_word,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // Stage enables: a stage moves when it is empty or its successor moves
  logic en0, en1, en2;

  // Input register stage
  logic                   v0_r;
  op_t                    op_r;
  logic [ENTRY_IDX_W-1:0] eidx_r;
  logic [ENTRY_VAL_W-1:0] eval_r;

  // Table read stage
  logic                   v1_r;
  logic [SAMPLE_BITS-1:0] lo_r;
  logic [SAMPLE_BITS-1:0] hi_r;
  logic [FRAC_BITS-1:0]   frac_r;

  // Output stage
  logic                   v2_r;
  logic [DAC_W-1:0]       dac_r;

  // Architectural state
  logic [PHASE_W-1:0]     phase_r;
  logic [PHASE_W-1:0]     phase_nxt;
  logic [INC_W-1:0]       inc_r;
  logic [SAMPLE_BITS-1:0] table_mem [TABLE_DEPTH];

  logic                   step_go;
  logic                   load_go;
  logic [PHASE_W:0]       phase_sum;
  logic [PINT_W-1:0]      phase_int;
  logic [IDX_W-1:0]       lo_idx;
  logic [IDX_W-1:0]       hi_idx;
  logic [WGT_W-1:0]       wgt_lo;
  logic [SUM_W-1:0]       interp_sum;
  logic [SAMPLE_BITS-1:0] interp_val;
  logic [SAMPLE_BITS+1:0] interp_shl;
  logic [DAC_W-1:0]       dac_nxt;
  logic                   cfg_wr;

  assign en2      = !v2_r || !out_stall;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_stall = !en0;

  // Configuration register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_PHASE_INC);

  always_comb begin
    prdata = '0;
    if (paddr == REG_PHASE_INC) begin
      prdata = CFG_DATA_W'(inc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= '0;
    end else if (cfg_wr) begin
      inc_r <= pwdata[INC_W-1:0];
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      op_r   <= op_t'(in_operation);
      eidx_r <= in_entry_index;
      eval_r <= in_entry_value;
    end
  end

  // Phase advance with a single wrap, and table addresses
  assign step_go = v0_r && en1 && (op_r == OP_STEP);
  assign load_go = v0_r && en1 && (op_r == OP_LOAD) && (int'(eidx_r) <= TABLE_SEGMENTS);

  always_comb begin
    phase_sum = {1'b0, phase_r} + (PHASE_W + 1)'(inc_r);
    if (phase_sum >= (PHASE_W + 1)'(PHASE_LIMIT)) begin
      phase_nxt = PHASE_W'(phase_sum - (PHASE_W + 1)'(PHASE_LIMIT));
    end else begin
      phase_nxt = PHASE_W'(phase_sum);
    end
    phase_int = phase_nxt[PHASE_W-1:FRAC_BITS];
    if (int'(phase_int) >= TABLE_SEGMENTS) begin
      lo_idx = IDX_W'(TABLE_SEGMENTS - 1);
    end else begin
      lo_idx = IDX_W'(phase_int);
    end
    hi_idx = lo_idx + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (step_go) begin
      phase_r <= phase_nxt;
    end
  end

  // Sample table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (load_go) begin
      table_mem[IDX_W'(eidx_r)] <= SAMPLE_BITS'(eval_r);
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      lo_r   <= table_mem[lo_idx];
      hi_r   <= table_mem[hi_idx];
      frac_r <= phase_nxt[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= v0_r && (op_r == OP_STEP);
    end
  end

  // Linear interpolation and DAC formatting
  always_comb begin
    wgt_lo     = WGT_W'(FRAC_ONE) - WGT_W'(frac_r);
    interp_sum = SUM_W'(lo_r) * SUM_W'(wgt_lo) + SUM_W'(hi_r) * SUM_W'(frac_r);
    interp_val = interp_sum[FRAC_BITS +: SAMPLE_BITS];
    interp_shl = {interp_val, 2'b00};
    dac_nxt    = DAC_W'(interp_shl) & DAC_MASK;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      dac_r <= dac_nxt;
    end
  end

  assign out_valid    = v2_r;
  assign out_dac_word = dac_r;

`ifndef SYNTHESIS
  // Phase never leaves the table range
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(phase_r) < PHASE_LIMIT)
    else $error("phase accumulator out of range");

  // A load moving out of the input register creates no result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && en1 && (op_r == OP_LOAD)) |=> !v1_r)
    else $error("load transaction produced a result");

  // A step moving out of the read stage shows up at the output
  a_step_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && en2) |=> out_valid)
    else $error("step transaction lost before output");

  // Phase only moves on a step leaving the input register
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_go |=> $stable(phase_r))
    else $error("phase changed without a step");
`endif

endmodule

### sim/interpolating_wavetable_oscillator_tb.sv
`timescale 1ns / 100ps

module interpolating_wavetable_oscillator_tb
  import iwo_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [OP_W-1:0]        in_operation;
  logic [ENTRY_IDX_W-1:0] in_entry_index;
  logic [ENTRY_VAL_W-1:0] in_entry_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [DAC_W-1:0]       out_dac_word;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [CFG_DATA_W-1:0]  pwdata;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  // Oscillator copy used for prediction
  logic [PHASE_W-1:0]     osc_phase;
  logic [INC_W-1:0]       osc_increment;
  logic [SAMPLE_BITS-1:0] osc_table [TABLE_DEPTH];

  logic [DAC_W-1:0] dac_words_due [$];
  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;

  interpolating_wavetable_oscillator uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dac_word  (out_dac_word),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("interpolating_wavetable_oscillator: mismatch");
      $finish;
    end
  end

  // Receiver: long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest predicted DAC word
  always @(posedge clk) begin
    logic [DAC_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (dac_words_due.size() == 0) begin
        $error("dac_word: expected none, actual %h", out_dac_word);
        error_count++;
      end else begin
        want = dac_words_due.pop_front();
        if (out_dac_word !== want) begin
          $error("dac_word: expected %h, actual %h", want, out_dac_word);
          error_count++;
        end
      end
    end
  end

  // Advance the phase and interpolate between neighboring table entries
  function automatic logic [DAC_W-1:0] next_dac_word();
    int unsigned acc;
    int unsigned seg;
    int unsigned frac;
    int unsigned mix;
    int unsigned level;
    acc = osc_phase + osc_increment;
    if (acc >= PHASE_LIMIT) acc = acc - PHASE_LIMIT;
    osc_phase = acc[PHASE_W-1:0];
    frac = acc % FRAC_ONE;
    seg = acc / FRAC_ONE;
    if (seg >= TABLE_SEGMENTS) seg = TABLE_SEGMENTS - 1;
    mix = osc_table[seg] * (FRAC_ONE - frac) + osc_table[seg + 1] * frac;
    level = mix >> FRAC_BITS;
    return DAC_W'(level << 2) & DAC_MASK;
  endfunction

  // Offer one transaction, wait for it to be taken, then update the prediction
  task automatic send_item(op_t op, logic [ENTRY_IDX_W-1:0] index,
                           logic [ENTRY_VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_entry_index <= index;
    in_entry_value <= value;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) begin
      if (index < TABLE_DEPTH) osc_table[index] = value[SAMPLE_BITS-1:0];
    end else begin
      dac_words_due.push_back(next_dac_word());
    end
    @(negedge clk);
  endtask

  // Stop offering, wait for all predicted results, then let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    while (dac_words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write followed by a readback
  task automatic write_increment(logic [INC_W-1:0] inc);
    logic [CFG_DATA_W-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_PHASE_INC;
    pwdata  <= CFG_DATA_W'(inc);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    osc_increment = inc;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    if (readback !== CFG_DATA_W'(inc)) begin
      $error("phase_increment: expected %h, actual %h", CFG_DATA_W'(inc), readback);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Fill the whole table, extremes at both ends, plus ignored out-of-range loads
  task automatic test_table_load();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (i)
        0, 35:   send_item(OP_LOAD, ENTRY_IDX_W'(i), '0);
        1, 36:   send_item(OP_LOAD, ENTRY_IDX_W'(i), '1);
        default: send_item(OP_LOAD, ENTRY_IDX_W'(i), ENTRY_VAL_W'($urandom_range(16383)));
      endcase
    end
    send_item(OP_LOAD, ENTRY_IDX_W'(TABLE_DEPTH), '1);
    send_item(OP_LOAD, '1, '0);
    drain();
  endtask

  // Zero and full-scale increment, then a single-step crawl
  task automatic test_increment_extremes();
    write_increment('0);
    repeat (3) send_item(OP_STEP, '1, '1);
    drain();
    write_increment('1);
    repeat (8) send_item(OP_STEP, ENTRY_IDX_W'($urandom_range(63)),
                         ENTRY_VAL_W'($urandom_range(16383)));
    drain();
    write_increment(INC_W'(1));
    repeat (3) send_item(OP_STEP, '0, '0);
    drain();
  endtask

  // Mostly steps with table rewrites mixed in, under one idling pattern
  task automatic test_mixed_traffic(int idle_pct, int stall_pct, int count,
                                    logic [INC_W-1:0] inc);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_increment(inc);
    repeat (count) begin
      if ($urandom_range(99) < 85)
        send_item(OP_STEP, ENTRY_IDX_W'($urandom_range(63)),
                  ENTRY_VAL_W'($urandom_range(16383)));
      else if ($urandom_range(9) == 0)
        send_item(OP_LOAD, ENTRY_IDX_W'($urandom_range(63)),
                  ($urandom_range(1) != 0) ? '1 : '0);
      else
        send_item(OP_LOAD, ENTRY_IDX_W'($urandom_range(63)),
                  ENTRY_VAL_W'($urandom_range(16383)));
    end
    drain();
  endtask

  // Receiver holds off long enough that the block backs up into its input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_increment(8'd200);
    hold_off_left = 120;
    repeat (50) send_item(OP_STEP, ENTRY_IDX_W'($urandom_range(63)),
                          ENTRY_VAL_W'($urandom_range(16383)));
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_LOAD;
    in_entry_index = '0;
    in_entry_value = '0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = REG_PHASE_INC;
    pwdata         = '0;
    osc_phase      = '0;
    osc_increment  = '0;
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 0;
    foreach (osc_table[i]) osc_table[i] = '0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_table_load();
    test_increment_extremes();
    test_mixed_traffic(0, 0, 200, '1);
    test_mixed_traffic(88, 0, 150, INC_W'($urandom_range(1, 254)));
    test_mixed_traffic(0, 88, 150, 8'd128);
    test_mixed_traffic(36, 36, 150, INC_W'($urandom_range(255)));
    test_backpressure();

    if (error_count == 0) begin
      $display("interpolating_wavetable_oscillator: match");
    end else begin
      $display("interpolating_wavetable_oscillator: mismatch");
    end
    $finish;
  end

endmodule
